/* design/jsu_pkg.sv */
// Shared types, codes and helper functions for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLOSED  = 2'd1;
  localparam logic [1:0] ST_UNTERM  = 2'd2;
  localparam logic [1:0] ST_BAD_HEX = 2'd3;

  // Number of hex digits in a \u escape.
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  // Kinds of work the front hands to the back.
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_CP
  } cmd_kind_t;

  // One command: a decoded byte, an end status or a code point to encode.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] data;
  } cmd_t;

  // Digit value 0..15, or 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    begin
      t = 8'd16;
      if (b >= 8'h30 && b <= 8'h39) begin
        t = b - 8'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
        t = b - 8'h57;
      end else if (b >= 8'h41 && b <= 8'h46) begin
        t = b - 8'h37;
      end
      return t[4:0];
    end
  endfunction

  // Byte produced by a backslash escape other than \u.
  function automatic logic [7:0] simple_escape(input logic [7:0] b);
    logic [7:0] r;
    begin
      unique case (b)
        8'h62:   r = 8'h08;  // b
        8'h66:   r = 8'h0C;  // f
        8'h6E:   r = 8'h0A;  // n
        8'h72:   r = 8'h0D;  // r
        8'h74:   r = 8'h09;  // t
        default: r = b;
      endcase
      return r;
    end
  endfunction

endpackage

/* design/jsu_front.sv */
// Front end: tracks escape state, gathers hex digits and emits commands.
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          end_of_input,
  output logic          cmd_valid,
  output jsu_pkg::cmd_t cmd
);

  logic        in_escape, in_escape_next;
  logic [2:0]  hex_left, hex_left_next;
  logic [15:0] code_point, code_point_next;
  logic [4:0]  digit;
  logic [15:0] cp_shift;

  assign digit    = jsu_pkg::hex_value(in_byte);
  assign cp_shift = {code_point[11:0], digit[3:0]};

  always_comb begin
    in_escape_next  = in_escape;
    hex_left_next   = hex_left;
    code_point_next = code_point;
    cmd_valid       = 1'b0;
    cmd.kind        = jsu_pkg::CMD_BYTE;
    cmd.data        = '0;
    priority if (end_of_input) begin
      in_escape_next  = 1'b0;
      hex_left_next   = '0;
      code_point_next = '0;
      cmd_valid       = 1'b1;
      cmd.kind        = jsu_pkg::CMD_END;
      cmd.data        = {14'd0, jsu_pkg::ST_UNTERM};
    end else if (hex_left != 3'd0) begin
      if (digit[4]) begin
        in_escape_next  = 1'b0;
        hex_left_next   = '0;
        code_point_next = '0;
        cmd_valid       = 1'b1;
        cmd.kind        = jsu_pkg::CMD_END;
        cmd.data        = {14'd0, jsu_pkg::ST_BAD_HEX};
      end else begin
        hex_left_next = hex_left - 3'd1;
        if (hex_left == 3'd1) begin
          code_point_next = '0;
          cmd_valid       = 1'b1;
          cmd.kind        = jsu_pkg::CMD_CP;
          cmd.data        = cp_shift;
        end else begin
          code_point_next = cp_shift;
        end
      end
    end else if (in_escape) begin
      in_escape_next = 1'b0;
      if (in_byte == 8'h75) begin
        hex_left_next   = jsu_pkg::HEX_DIGITS;
        code_point_next = '0;
      end else begin
        cmd_valid = 1'b1;
        cmd.kind  = jsu_pkg::CMD_BYTE;
        cmd.data  = {8'd0, jsu_pkg::simple_escape(in_byte)};
      end
    end else if (in_byte == 8'h22) begin
      hex_left_next   = '0;
      code_point_next = '0;
      cmd_valid       = 1'b1;
      cmd.kind        = jsu_pkg::CMD_END;
      cmd.data        = {14'd0, jsu_pkg::ST_CLOSED};
    end else if (in_byte == 8'h5C) begin
      in_escape_next = 1'b1;
    end else begin
      cmd_valid = 1'b1;
      cmd.kind  = jsu_pkg::CMD_BYTE;
      cmd.data  = {8'd0, in_byte};
    end
    if (!accept) begin
      cmd_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape  <= 1'b0;
      hex_left   <= '0;
      code_point <= '0;
    end else if (accept) begin
      in_escape  <= in_escape_next;
      hex_left   <= hex_left_next;
      code_point <= code_point_next;
    end
  end

endmodule

/* design/jsu_queue.sv */
// Small command queue between the front and the back.
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  jsu_pkg::cmd_t wr_data,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::cmd_t head,
  input  logic          rd_en
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* design/jsu_back.sv */
// Back end: expands commands into result items, UTF-8 encoding code points.
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  jsu_pkg::cmd_t head,
  output logic          head_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          last,
  output logic [1:0]    status
);

  logic       out_full;
  logic [1:0] step;
  logic       load;
  logic [7:0] p_byte;
  logic       p_valid;
  logic [1:0] p_status;
  logic       p_last;
  logic [15:0] cp;

  assign cp = head.data;

  // Piece of the head command selected by the step counter.
  always_comb begin
    p_byte   = '0;
    p_valid  = 1'b1;
    p_status = jsu_pkg::ST_OK;
    p_last   = 1'b1;
    unique case (head.kind)
      jsu_pkg::CMD_BYTE: begin
        p_byte = cp[7:0];
      end
      jsu_pkg::CMD_END: begin
        p_valid  = 1'b0;
        p_status = cp[1:0];
      end
      jsu_pkg::CMD_CP: begin
        if (cp < 16'h0080) begin
          p_byte = cp[7:0];
        end else if (cp < 16'h0800) begin
          if (step == 2'd0) begin
            p_byte = 8'hC0 | {3'd0, cp[10:6]};
            p_last = 1'b0;
          end else begin
            p_byte = 8'h80 | {2'd0, cp[5:0]};
          end
        end else begin
          priority case (step)
            2'd0: begin
              p_byte = 8'hE0 | {4'd0, cp[15:12]};
              p_last = 1'b0;
            end
            2'd1: begin
              p_byte = 8'h80 | {2'd0, cp[11:6]};
              p_last = 1'b0;
            end
            default: begin
              p_byte = 8'h80 | {2'd0, cp[5:0]};
            end
          endcase
        end
      end
      default: begin
        p_valid = 1'b0;
      end
    endcase
  end

  assign load     = head_valid && (!out_full || pop);
  assign head_pop = load && p_last;
  assign empty    = !out_full;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= p_byte;
      byte_valid <= p_valid;
      last       <= p_last;
      status     <= p_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      step     <= '0;
    end else begin
      if (load) begin
        out_full <= 1'b1;
        step     <= p_last ? 2'd0 : step + 2'd1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

/* design/json_string_unescape_utf8_top.sv */
// Top level of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

// Usage:
// The input side is a queue: drive in_byte and end_of_input, raise push, and
// the item is taken at a rising edge where push is high and full is low.
// Each item is one byte of a JSON string body after the opening quote, or an
// end-of-input marker. The result side is a queue too: while empty is low,
// the oldest result item sits on out_byte, byte_valid, last and status, and
// it is taken at a rising edge where pop is high and empty is low.
// An input item gives zero to three result items; last marks the final one.
// Path: a result item passes through the command queue and then the output
// register before it reaches the output ports.
// Throughput: one input item per cycle while full is low and one result
// item per cycle while pop is high; a three-byte UTF-8 sequence gives three
// result items, but its \u escape spends six input items, so with pop held
// high the back end keeps up and full does not rise.
// When the receiver stalls, the output register holds its item, the queue
// fills, and full rises once QUEUE_DEPTH commands are waiting.
// Synchronous reset clears the escape state and the queue and marks the output
// register empty; no item is lost or invented across a stall.
module json_string_unescape_utf8_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last,
  output logic [1:0] status
);

  logic          accept;
  logic          cmd_valid;
  jsu_pkg::cmd_t cmd;
  logic          head_valid;
  jsu_pkg::cmd_t head;
  logic          head_pop;

  // An item is taken when push is high and the command queue has room.
  assign accept = push && !full;

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cmd_valid),
    .wr_data    (cmd),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .rd_en      (head_pop)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module tb;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_Z         = 8'h7A;

  // Control bytes that the simple escapes stand for.
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  // Value returned for a byte that is not a hex digit.
  localparam logic [4:0] NOT_HEX = 5'd16;

  // One input item: a raw body byte, or the end-of-input marker.
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } in_item_t;

  // One result item as it appears on the output ports.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic [1:0] status;
  } result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;

  json_string_unescape_utf8_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status)
  );

  always #5 clk = ~clk;

  // Items waiting to be sent, and decoded bytes waiting to come out.
  in_item_t pending_items[$];
  result_t  expected_bytes[$];
  int       errors = 0;
  int       queued_items = 0;

  // Pacing knobs. The initial block changes them only at falling edges, so the
  // clocked processes never see them change within a rising-edge time step.
  int          gap_max = 0;
  logic [15:0] pop_mask = 16'hFFFF;

  // Decoder state as the predictor tracks it.
  logic        esc_pending = 1'b0;
  logic [2:0]  digits_left = 3'd0;
  logic [15:0] cp_acc = 16'h0000;

  // Returns the value of a hex digit, or NOT_HEX for any other byte.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") begin
      return {1'b0, b[3:0]};
    end
    if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
      return {1'b0, b[3:0] + 4'd9};
    end
    return NOT_HEX;
  endfunction

  function automatic void expect_byte(input logic [7:0] data, input logic valid,
                                      input logic is_last, input logic [1:0] st);
    result_t r;
    r.data = data;
    r.valid = valid;
    r.last = is_last;
    r.status = st;
    expected_bytes.insert(expected_bytes.size(), r);
  endfunction

  function automatic void clear_decoder();
    esc_pending = 1'b0;
    digits_left = 3'd0;
    cp_acc = 16'h0000;
  endfunction

  // Advances the predicted decoder by one accepted item and queues the
  // decoded bytes that it causes.
  function automatic void unescape_step(input in_item_t it);
    logic [4:0]  d;
    logic [15:0] cp;
    if (it.eoi) begin
      clear_decoder();
      expect_byte(8'h00, 1'b0, 1'b1, jsu_pkg::ST_UNTERM);
      return;
    end
    if (digits_left != 3'd0) begin
      d = hex_digit(it.b);
      if (d == NOT_HEX) begin
        clear_decoder();
        expect_byte(8'h00, 1'b0, 1'b1, jsu_pkg::ST_BAD_HEX);
        return;
      end
      cp_acc = {cp_acc[11:0], d[3:0]};
      digits_left = digits_left - 3'd1;
      if (digits_left != 3'd0) begin
        return;
      end
      cp = cp_acc;
      cp_acc = 16'h0000;
      // One, two or three UTF-8 bytes depending on the size of the code point.
      if (cp < 16'h0080) begin
        expect_byte(cp[7:0], 1'b1, 1'b1, jsu_pkg::ST_OK);
      end else if (cp < 16'h0800) begin
        expect_byte(8'hC0 | {3'd0, cp[10:6]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
        expect_byte(8'h80 | {2'd0, cp[5:0]}, 1'b1, 1'b1, jsu_pkg::ST_OK);
      end else begin
        expect_byte(8'hE0 | {4'd0, cp[15:12]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
        expect_byte(8'h80 | {2'd0, cp[11:6]}, 1'b1, 1'b0, jsu_pkg::ST_OK);
        expect_byte(8'h80 | {2'd0, cp[5:0]}, 1'b1, 1'b1, jsu_pkg::ST_OK);
      end
      return;
    end
    if (esc_pending) begin
      esc_pending = 1'b0;
      case (it.b)
        CH_U: begin
          digits_left = jsu_pkg::HEX_DIGITS;
          cp_acc = 16'h0000;
        end
        CH_B:    expect_byte(CTL_BS, 1'b1, 1'b1, jsu_pkg::ST_OK);
        CH_F:    expect_byte(CTL_FF, 1'b1, 1'b1, jsu_pkg::ST_OK);
        CH_N:    expect_byte(CTL_LF, 1'b1, 1'b1, jsu_pkg::ST_OK);
        CH_R:    expect_byte(CTL_CR, 1'b1, 1'b1, jsu_pkg::ST_OK);
        CH_T:    expect_byte(CTL_TAB, 1'b1, 1'b1, jsu_pkg::ST_OK);
        default: expect_byte(it.b, 1'b1, 1'b1, jsu_pkg::ST_OK);
      endcase
      return;
    end
    if (it.b == CH_QUOTE) begin
      clear_decoder();
      expect_byte(8'h00, 1'b0, 1'b1, jsu_pkg::ST_CLOSED);
    end else if (it.b == CH_BACKSLASH) begin
      esc_pending = 1'b1;
    end else begin
      expect_byte(it.b, 1'b1, 1'b1, jsu_pkg::ST_OK);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. The item on the ports is the one held in on_wire; when it is taken
  // it goes through the predictor, and the next item is loaded from the queue
  // unless the sender is in a gap between bursts.
  // ---------------------------------------------------------------------------
  in_item_t on_wire;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        unescape_step(on_wire);
      end
      // A held item stays on the ports until the block takes it.
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_wire = pending_items.pop_front();
          in_byte <= on_wire.b;
          end_of_input <= on_wire.eoi;
          push <= 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result item taken from the block is checked field by field
  // against the oldest prediction. The receiver stalls on a rotating 16-bit
  // pattern that the test phases change.
  // ---------------------------------------------------------------------------
  int pop_slot = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result item: out_byte %h byte_valid %b last %b status %0d",
                 out_byte, byte_valid, last, status);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            errors++;
          end
          if (byte_valid !== want.valid) begin
            $error("byte_valid: expected %b, got %b", want.valid, byte_valid);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
        end
      end
      pop <= pop_mask[pop_slot];
      pop_slot = (pop_slot + 1) % 16;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building blocks.
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    in_item_t it;
    it.b = b;
    it.eoi = 1'b0;
    pending_items.insert(pending_items.size(), it);
    queued_items++;
  endtask

  // The byte beside an end-of-input marker is random, since it must be ignored.
  task automatic add_end();
    in_item_t it;
    it.b = 8'($urandom_range(0, 255));
    it.eoi = 1'b1;
    pending_items.insert(pending_items.size(), it);
    queued_items++;
  endtask

  // Queues a \u escape; the case of the letter digits is random.
  task automatic add_unicode(input logic [15:0] cp);
    logic [3:0] nib;
    logic [7:0] c;
    add_byte(CH_BACKSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) begin
      nib = cp[i*4 +: 4];
      if (nib < 4'd10) begin
        c = "0" + nib;
      end else begin
        c = ($urandom_range(0, 1) ? "a" : "A") + nib - 4'd10;
      end
      add_byte(c);
    end
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_QUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (hex_digit(b) != NOT_HEX);
    return b;
  endfunction

  // A string body with random content. Most end with a closing quote; the
  // rest run out of input or break off inside an escape.
  task automatic add_string();
    int          n;
    int          kind;
    int          digits;
    logic [7:0]  letter;
    logic [7:0]  esc_letters[9];
    esc_letters = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_Z};
    n = $urandom_range(0, 6);
    repeat (n) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        add_byte(plain_byte());
      end else if (kind < 6) begin
        // Known escape letters, or any byte but u for an unknown escape.
        if ($urandom_range(0, 2) != 0) begin
          letter = esc_letters[$urandom_range(0, 8)];
        end else begin
          do begin
            letter = 8'($urandom_range(0, 255));
          end while (letter == CH_U);
        end
        add_byte(CH_BACKSLASH);
        add_byte(letter);
      end else begin
        case ($urandom_range(0, 2))
          0:       add_unicode(16'($urandom_range(16'h0000, 16'h007F)));
          1:       add_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
          default: add_unicode(16'($urandom_range(16'h0800, 16'hFFFF)));
        endcase
      end
    end
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      add_byte(CH_QUOTE);
    end else if (kind == 7) begin
      add_end();
    end else begin
      // Break off a \u escape after zero to three good digits.
      add_byte(CH_BACKSLASH);
      add_byte(CH_U);
      digits = $urandom_range(0, 3);
      repeat (digits) begin
        add_byte(8'("0" + $urandom_range(0, 9)));
      end
      if (kind == 8) begin
        add_byte($urandom_range(0, 3) == 0 ? CH_QUOTE : non_hex_byte());
      end else begin
        add_end();
      end
    end
  endtask

  // Raw noise: any byte at all, now and then an end-of-input marker.
  task automatic add_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 15) == 0) begin
        add_end();
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic add_random(input int count);
    int target;
    target = queued_items + count;
    while (queued_items < target) begin
      if ($urandom_range(0, 9) < 8) begin
        add_string();
      end else begin
        add_noise();
      end
    end
  endtask

  // Waits until every queued item is taken and every
  // predicted result has come out.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || push || expected_bytes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: byte extremes, escapes, one- and three-byte UTF-8 with a
    // surrogate half, closing quote, a quote where a hex digit is due, and
    // end of input. Light idling on both sides.
    gap_max = 3;
    pop_mask = 16'($urandom_range(1, 16'hFFFF));
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_BACKSLASH);
    add_byte(CH_N);
    add_byte(CH_BACKSLASH);
    add_byte(CH_QUOTE);
    add_byte(CH_BACKSLASH);
    add_byte(CH_Z);
    add_unicode(16'h0000);
    add_unicode(16'hD83D);
    add_byte(CH_QUOTE);
    add_byte(CH_BACKSLASH);
    add_byte(CH_U);
    add_byte("1");
    add_byte(CH_QUOTE);
    add_end();
    drain();

    // Random traffic with gaps on the input and stalls on the output.
    gap_max = 6;
    pop_mask = 16'($urandom_range(1, 16'hFFFF));
    add_random(100);
    drain();

    // Full rate on both sides, so the command queue sees back-to-back items.
    gap_max = 0;
    pop_mask = 16'hFFFF;
    add_random(60);
    drain();

    // Heavy output stall with an eager sender, so full rises often.
    gap_max = 2;
    pop_mask = 16'($urandom_range(0, 16'hFFFF) & $urandom_range(0, 16'hFFFF)) | 16'h0001;
    add_random(60);
    drain();

    // Let any stray result item show itself before the verdict.
    pop_mask = 16'hFFFF;
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
